// ===== rtl/core/tmcd_pkg.sv =====
// shared constants, types and tables of the text mode column drawer
`default_nettype none
package tmcd_pkg;

   localparam int SCREEN_COLUMNS  = 80;
   localparam int SCREEN_ROWS     = 25;
   localparam int TEXEL_DEPTH     = 128;
   localparam int SHADE_MAP_COUNT = 32;   // power of two, map index is a bit slice
   localparam int FUZZ_LENGTH     = 50;

   localparam int ROW_W     = $clog2(SCREEN_ROWS);
   localparam int COL_W     = $clog2(SCREEN_COLUMNS);
   localparam int ADDR_W    = 12;
   localparam int ROW_PITCH = SCREEN_COLUMNS * 2;
   localparam int TEXEL_W   = $clog2(TEXEL_DEPTH);
   localparam int MAP_W     = (SHADE_MAP_COUNT > 1) ? $clog2(SHADE_MAP_COUNT) : 1;
   localparam int SHADE_DEPTH = SHADE_MAP_COUNT * 256;
   localparam int FUZZ_W    = $clog2(FUZZ_LENGTH);

   localparam int MID_SHIFT   = 8 - 1;
   localparam int TEXEL_SHIFT = 8 + 1;

   localparam logic [7:0] ATTR_NORMAL = 8'h07;
   localparam logic [7:0] ATTR_BRIGHT = 8'h0f;
   localparam logic [7:0] FUZZ_DARK   = 8'h00;
   localparam logic [7:0] FUZZ_SHADE  = 8'hb0;

   localparam logic [2:0] KIND_WALL       = 3'd0;
   localparam logic [2:0] KIND_SPRITE     = 3'd1;
   localparam logic [2:0] KIND_FLAT       = 3'd2;
   localparam logic [2:0] KIND_FUZZ       = 3'd3;
   localparam logic [2:0] KIND_LOAD_TEXEL = 3'd4;
   localparam logic [2:0] KIND_LOAD_SHADE = 3'd5;

   // one row handed from the sequencer to the lookup pipeline
   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  addr;
      logic               last;
      logic               textured;
      logic [7:0]         char_byte;
      logic [7:0]         attr;
      logic [MAP_W-1:0]   map;
      logic [TEXEL_W-1:0] texel_addr;
   } row_issue_type;

   // table load write
   typedef struct packed {
      logic             texel_we;
      logic             shade_we;
      logic [MAP_W-1:0] map;
      logic [7:0]       index;
      logic [7:0]       value;
   } load_write_type;

   function automatic logic [7:0] fuzz_char(input logic [FUZZ_W-1:0] pos);
      logic [7:0] ch;
      case (pos)
         6'd1, 6'd3, 6'd6, 6'd9, 6'd13, 6'd17, 6'd18, 6'd19, 6'd20, 6'd22, 6'd23,
         6'd28, 6'd30, 6'd33, 6'd34, 6'd37, 6'd38, 6'd39, 6'd40, 6'd45,
         6'd48: ch = FUZZ_SHADE;
         default: ch = FUZZ_DARK;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tmcd_if.sv =====
// valid/ready channel interfaces for draw requests and cell writes
`default_nettype none
interface tmcd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [6:0]  column;
   logic [4:0]  row_top;
   logic [4:0]  row_bottom;
   logic signed [31:0] texture_mid;
   logic [15:0] frac_step;
   logic [7:0]  flat_color;
   logic [4:0]  map_select;
   logic [7:0]  table_index;
   logic [7:0]  table_value;

   modport source (output valid, kind, column, row_top, row_bottom, texture_mid, frac_step,
                   flat_color, map_select, table_index, table_value, input ready);
   modport sink (input valid, kind, column, row_top, row_bottom, texture_mid, frac_step,
                 flat_color, map_select, table_index, table_value, output ready);
endinterface

interface tmcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] cell_address;
   logic [7:0]  char_byte;
   logic [7:0]  attribute_byte;
   logic        last;

   modport source (output valid, cell_address, char_byte, attribute_byte, last,
                   input ready);
   modport sink (input valid, cell_address, char_byte, attribute_byte, last,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tmcd_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module tmcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tmcd_seq.sv =====
// request intake and row sequencer
`default_nettype none
module tmcd_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   tmcd_req_if.sink                      req_bus,
   input  wire logic [4:0]               center_row,
   input  wire logic                     advance,
   input  wire logic                     pipe_empty,
   output      tmcd_pkg::row_issue_type  issue,
   output      tmcd_pkg::load_write_type load
);

   typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_ROWS} state_type;

   state_type                         state_ff, state_in;
   logic [tmcd_pkg::FUZZ_W-1:0]       fuzz_ff, fuzz_in;
   logic [2:0]                        kind_ff, kind_in;
   logic [7:0]                        flat_ff, flat_in;
   logic [tmcd_pkg::MAP_W-1:0]        map_ff, map_in;
   logic [tmcd_pkg::COL_W-1:0]        col_ff, col_in;
   logic [tmcd_pkg::ROW_W-1:0]        top_ff, top_in;
   logic [tmcd_pkg::ROW_W-1:0]        bot_ff, bot_in;
   logic [tmcd_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [15:0]                       mid_ff, mid_in;
   logic [15:0]                       step_ff, step_in;
   logic [15:0]                       frac_ff, frac_in;
   logic [tmcd_pkg::ADDR_W-1:0]       addr_ff, addr_in;

   logic                              accept;
   logic [tmcd_pkg::ROW_W-1:0]        top_sat, bot_sat;
   logic [tmcd_pkg::COL_W-1:0]        col_sat;
   logic [15:0]                       row_delta;
   logic [31:0]                       delta_prod;
   logic                              is_last;

   assign req_bus.ready = (state_ff == ST_IDLE) && pipe_empty;
   assign accept        = req_bus.valid && req_bus.ready;

   // clamp rows and column onto the screen
   assign top_sat = (32'(req_bus.row_top) > tmcd_pkg::SCREEN_ROWS - 1)
                  ? tmcd_pkg::ROW_W'(tmcd_pkg::SCREEN_ROWS - 1)
                  : tmcd_pkg::ROW_W'(req_bus.row_top);
   assign bot_sat = (32'(req_bus.row_bottom) > tmcd_pkg::SCREEN_ROWS - 1)
                  ? tmcd_pkg::ROW_W'(tmcd_pkg::SCREEN_ROWS - 1)
                  : tmcd_pkg::ROW_W'(req_bus.row_bottom);
   assign col_sat = (32'(req_bus.column) > tmcd_pkg::SCREEN_COLUMNS - 1)
                  ? tmcd_pkg::COL_W'(tmcd_pkg::SCREEN_COLUMNS - 1)
                  : tmcd_pkg::COL_W'(req_bus.column);

   assign row_delta  = 16'(top_ff) - 16'(center_row);
   assign delta_prod = row_delta * step_ff;
   assign is_last    = (row_ff == bot_ff);

   // table loads go straight to the rams at accept
   always_comb begin
      load.texel_we = accept && (req_bus.kind == tmcd_pkg::KIND_LOAD_TEXEL);
      load.shade_we = accept && (req_bus.kind == tmcd_pkg::KIND_LOAD_SHADE);
      load.map      = req_bus.map_select[tmcd_pkg::MAP_W-1:0];
      load.index    = req_bus.table_index;
      load.value    = req_bus.table_value;
   end

   always_comb begin
      issue.valid      = (state_ff == ST_ROWS);
      issue.addr       = addr_ff;
      issue.last       = is_last;
      issue.textured   = (kind_ff == tmcd_pkg::KIND_WALL) ||
                         (kind_ff == tmcd_pkg::KIND_SPRITE);
      issue.char_byte  = (kind_ff == tmcd_pkg::KIND_FLAT) ? flat_ff
                                                          : tmcd_pkg::fuzz_char(fuzz_ff);
      issue.attr       = (kind_ff == tmcd_pkg::KIND_SPRITE) ? tmcd_pkg::ATTR_BRIGHT
                                                            : tmcd_pkg::ATTR_NORMAL;
      issue.map        = map_ff;
      issue.texel_addr = frac_ff[15 -: tmcd_pkg::TEXEL_W];
   end

   always_comb begin
      state_in = state_ff;
      fuzz_in  = fuzz_ff;
      kind_in  = kind_ff;
      flat_in  = flat_ff;
      map_in   = map_ff;
      col_in   = col_ff;
      top_in   = top_ff;
      bot_in   = bot_ff;
      row_in   = row_ff;
      mid_in   = mid_ff;
      step_in  = step_ff;
      frac_in  = frac_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_bus.kind;
               flat_in = req_bus.flat_color;
               map_in  = req_bus.map_select[tmcd_pkg::MAP_W-1:0];
               col_in  = col_sat;
               top_in  = top_sat;
               bot_in  = bot_sat;
               mid_in  = req_bus.texture_mid[tmcd_pkg::MID_SHIFT +: 16];
               step_in = req_bus.frac_step;
               if ((req_bus.kind <= tmcd_pkg::KIND_FUZZ) && !(bot_sat < top_sat)) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            frac_in  = mid_ff + delta_prod[15:0];
            addr_in  = tmcd_pkg::ADDR_W'(top_ff) * tmcd_pkg::ADDR_W'(tmcd_pkg::ROW_PITCH)
                     + tmcd_pkg::ADDR_W'({col_ff, 1'b0});
            row_in   = top_ff;
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            if (advance) begin
               row_in  = row_ff + 1'b1;
               addr_in = addr_ff + tmcd_pkg::ADDR_W'(tmcd_pkg::ROW_PITCH);
               frac_in = frac_ff + step_ff;
               if (kind_ff == tmcd_pkg::KIND_FUZZ) begin
                  fuzz_in = (fuzz_ff == tmcd_pkg::FUZZ_W'(tmcd_pkg::FUZZ_LENGTH - 1))
                          ? '0 : fuzz_ff + 1'b1;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fuzz_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fuzz_ff  <= fuzz_in;
      end
      kind_ff <= kind_in;
      flat_ff <= flat_in;
      map_ff  <= map_in;
      col_ff  <= col_in;
      top_ff  <= top_in;
      bot_ff  <= bot_in;
      row_ff  <= row_in;
      mid_ff  <= mid_in;
      step_ff <= step_in;
      frac_ff <= frac_in;
      addr_ff <= addr_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/tmcd_lookup.sv =====
// texel and shade lookup pipeline with output register
`default_nettype none
module tmcd_lookup (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tmcd_pkg::row_issue_type  issue,
   input  wire tmcd_pkg::load_write_type load,
   tmcd_rsp_if.source                    rsp_bus,
   output      logic                     advance,
   output      logic                     pipe_empty
);

   tmcd_pkg::row_issue_type p1_ff, p2_ff;
   logic                    out_valid_ff;
   logic [11:0]             out_addr_ff;
   logic [7:0]              out_char_ff;
   logic [7:0]              out_attr_ff;
   logic                    out_last_ff;
   logic [7:0]              texel_rdata;
   logic [7:0]              shade_rdata;
   logic [7:0]              char_in;

   // whole pipe, ram read registers included, moves together
   assign advance    = !out_valid_ff || rsp_bus.ready;
   assign pipe_empty = !p1_ff.valid && !p2_ff.valid;

   tmcd_ram #(
      .WIDTH (8),
      .DEPTH (tmcd_pkg::TEXEL_DEPTH)
   ) u_texel_ram (
      .clock    (clock),
      .we       (load.texel_we),
      .waddr    (load.index[tmcd_pkg::TEXEL_W-1:0]),
      .wdata    (load.value),
      .re       (advance),
      .raddr    (issue.texel_addr),
      .rdata_ff (texel_rdata)
   );

   tmcd_ram #(
      .WIDTH (8),
      .DEPTH (tmcd_pkg::SHADE_DEPTH)
   ) u_shade_ram (
      .clock    (clock),
      .we       (load.shade_we),
      .waddr    ({load.map, load.index}),
      .wdata    (load.value),
      .re       (advance),
      .raddr    ({p1_ff.map, texel_rdata}),
      .rdata_ff (shade_rdata)
   );

   assign char_in = p2_ff.textured ? shade_rdata : p2_ff.char_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff        <= '0;
         p2_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_ff        <= issue;
         p2_ff        <= p1_ff;
         out_valid_ff <= p2_ff.valid;
      end
      if (advance) begin
         out_addr_ff <= p2_ff.addr;
         out_char_ff <= char_in;
         out_attr_ff <= p2_ff.attr;
         out_last_ff <= p2_ff.last;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.cell_address   = out_addr_ff;
   assign rsp_bus.char_byte      = out_char_ff;
   assign rsp_bus.attribute_byte = out_attr_ff;
   assign rsp_bus.last           = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/text_mode_column_drawer_top.sv =====
// top level of the text mode column drawer
//
//  channel   dir  handshake          carries
//  req_bus   in   valid/ready        draw or table load item
//  rsp_bus   out  valid/ready        one cell write per drawn row
//  csr_*     in   csr_we, no wait    center_row register
//
// a draw item passes through accept, a set-up state for the start fraction and
// address, one row issue per drawn row, then a drain of the chained texel and
// shade memory reads before the next item is taken
// loads and empty or unused kinds stay in the idle state; reset is synchronous
// and clears control state only, the tables stay undefined until loaded
// a stalled result stalls the whole lookup pipe, the output register holds it
`default_nettype none
module text_mode_column_drawer_top (
   input  wire logic  clock,
   input  wire logic  reset,
   tmcd_req_if.sink   req_bus,
   tmcd_rsp_if.source rsp_bus,
   input  wire logic  csr_we,
   input  wire logic [4:0] csr_wdata
);

   logic [4:0]               center_row_ff;
   logic                     advance;
   logic                     pipe_empty;
   tmcd_pkg::row_issue_type  issue;
   tmcd_pkg::load_write_type load;

   // anchor row of the texture middle, reset to mid screen
   always_ff @(posedge clock) begin
      if (reset) begin
         center_row_ff <= 5'd12;
      end else if (csr_we) begin
         center_row_ff <= csr_wdata;
      end
   end

   // intake, set-up and one row per cycle while the lookup pipe advances
   tmcd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .center_row (center_row_ff),
      .advance    (advance),
      .pipe_empty (pipe_empty),
      .issue      (issue),
      .load       (load)
   );

   // texel read, shade read, output register
   tmcd_lookup u_lookup (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .load       (load),
      .rsp_bus    (rsp_bus),
      .advance    (advance),
      .pipe_empty (pipe_empty)
   );

endmodule
`default_nettype wire
